// ===== rtl/link_failover_backoff_controller_defines.svh =====
// Assertion macros for the link failover controller.
`ifndef LINK_FAILOVER_BACKOFF_CONTROLLER_DEFINES_SVH
`define LINK_FAILOVER_BACKOFF_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfbc_pkg.sv =====
package lfbc_pkg;

    localparam int REG_W            = 20;
    localparam int TICK_W_DEFAULT   = 20;
    localparam int CFG_INDEX_W      = 2;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 24;

    localparam logic [REG_W-1:0] RST_FALLBACK_DELAY = REG_W'(15000);
    localparam logic [REG_W-1:0] RST_PROBE_MIN      = REG_W'(30000);
    localparam logic [REG_W-1:0] RST_PROBE_MAX      = REG_W'(300000);
    localparam logic [REG_W-1:0] RST_FLAP_WINDOW    = REG_W'(300000);

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_DELAY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_MIN      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_MAX      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAP_WINDOW    = 2'd3;

    typedef struct packed {
        logic [REG_W-1:0] current_interval;
        logic             restart_links;
        logic             start_probe;
        logic             fallback_engaged;
    } t_result;

endpackage

// ===== rtl/link_failover_backoff_controller.sv =====
// Channel   Dir  Word contents (lowest bit up)
// s_axis    in   path_allowed, still_connecting, probe_done, probe_ok, 4 zero bits
// m_axis    out  fallback_engaged, start_probe, restart_links, current_interval[19:0],
//                1 zero bit
// cfg       in   one register write per cycle, index 0..3, no read-back
//
// One input word is one tick; a word is taken every cycle unless the output stalls,
// and its result enters the output register in the cycle after acceptance. The
// output register is the only buffer: a word is taken whenever that register is empty
// or is being drained. Reset is synchronous, active low; it clears all tick state and
// loads the configuration defaults. A stalled result holds and blocks further input.
`include "link_failover_backoff_controller_defines.svh"

module link_failover_backoff_controller #(
    parameter int TICK_COUNT_WIDTH = lfbc_pkg::TICK_W_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // path_allowed, still_connecting, probe_done, probe_ok, zero pad
    input  logic [lfbc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // fallback_engaged, start_probe, restart_links, current_interval, zero pad
    output logic [lfbc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic                                 i_cfg_wr_en,
    input  logic [lfbc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lfbc_pkg::REG_W-1:0]           i_cfg_data
);

    localparam int RW = lfbc_pkg::REG_W;
    localparam int TW = TICK_COUNT_WIDTH;
    // common width for comparing tick counters against registers
    localparam int CW = (TW > RW) ? TW : RW;
    localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

    // configuration registers
    logic [RW-1:0] r_fallback_delay, r_probe_min, r_probe_max, r_flap_window;

    // tick state
    logic          r_engaged, r_probing, r_conn_active, r_restore_valid, r_armed;
    logic [TW-1:0] r_conn_ticks, r_since_restore;
    logic [RW-1:0] r_interval, r_countdown;

    logic          n_engaged, n_probing, n_conn_active, n_restore_valid, n_armed;
    logic [TW-1:0] n_conn_ticks, n_since_restore;
    logic [RW-1:0] n_interval, n_countdown;
    logic          n_start, n_restart;

    // output register
    logic                r_out_valid;
    lfbc_pkg::t_result   r_out;

    logic s_accept, m_accept;
    logic in_allowed, in_connecting, in_done, in_ok;

    assign in_allowed    = i_s_axis_tdata[0];
    assign in_connecting = i_s_axis_tdata[1];
    assign in_done       = i_s_axis_tdata[2];
    assign in_ok         = i_s_axis_tdata[3];

    // take a word when the result register is empty or drains this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_accept        = r_out_valid && i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

    // configuration writes; indexes are exhaustive over the two-bit field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback_delay <= lfbc_pkg::RST_FALLBACK_DELAY;
            r_probe_min      <= lfbc_pkg::RST_PROBE_MIN;
            r_probe_max      <= lfbc_pkg::RST_PROBE_MAX;
            r_flap_window    <= lfbc_pkg::RST_FLAP_WINDOW;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lfbc_pkg::CFG_FALLBACK_DELAY: r_fallback_delay <= i_cfg_data;
                lfbc_pkg::CFG_PROBE_MIN:      r_probe_min      <= i_cfg_data;
                lfbc_pkg::CFG_PROBE_MAX:      r_probe_max      <= i_cfg_data;
                lfbc_pkg::CFG_FLAP_WINDOW:    r_flap_window    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One tick: age restore counter, outcome, engage rules, countdown.
    always_comb begin
        logic          new_arm;
        logic [RW:0]   doubled;
        new_arm         = 1'b0;
        doubled         = {r_interval, 1'b0};
        n_engaged       = r_engaged;
        n_probing       = r_probing;
        n_conn_active   = r_conn_active;
        n_restore_valid = r_restore_valid;
        n_armed         = r_armed;
        n_conn_ticks    = r_conn_ticks;
        n_since_restore = r_since_restore;
        n_interval      = r_interval;
        n_countdown     = r_countdown;
        n_start         = 1'b0;
        n_restart       = 1'b0;

        // age the restore counter, saturating
        if (r_restore_valid && (r_since_restore != TICK_MAX))
            n_since_restore = r_since_restore + 1'b1;

        // probe outcome; a stray outcome with no probe pending is dropped
        if (in_done && r_probing) begin
            n_probing = 1'b0;
            if (r_engaged) begin
                if (!in_ok) begin
                    n_countdown = r_interval;
                    n_armed     = 1'b1;
                    new_arm     = 1'b1;
                end else begin
                    n_engaged       = 1'b0;
                    n_restore_valid = 1'b1;
                    n_since_restore = '0;
                    n_restart       = 1'b1;
                end
            end
        end

        // engage rules
        if (!in_allowed) begin
            n_conn_active = 1'b0;
            n_conn_ticks  = '0;
            if (n_engaged) begin
                // permission lost: clear everything, restart links
                n_probing       = 1'b0;
                n_engaged       = 1'b0;
                n_restore_valid = 1'b0;
                n_since_restore = '0;
                n_interval      = r_probe_min;
                n_countdown     = '0;
                n_armed         = 1'b0;
                n_restart       = 1'b1;
                new_arm         = 1'b0;
            end
        end else if (n_engaged) begin
            // hold while engaged
        end else if (!in_connecting) begin
            n_conn_active = 1'b0;
            n_conn_ticks  = '0;
        end else if (!r_conn_active) begin
            n_conn_active = 1'b1;
            n_conn_ticks  = '0;
        end else begin
            if (r_conn_ticks != TICK_MAX)
                n_conn_ticks = r_conn_ticks + 1'b1;
            if (CW'(n_conn_ticks) >= CW'(r_fallback_delay)) begin
                // flapping back inside the window doubles the interval, capped
                if (n_restore_valid && (CW'(n_since_restore) < CW'(r_flap_window)))
                    n_interval = (doubled < {1'b0, r_probe_max}) ? doubled[RW-1:0]
                                                                 : r_probe_max;
                else
                    n_interval = r_probe_min;
                n_conn_active = 1'b0;
                n_conn_ticks  = '0;
                n_engaged     = 1'b1;
                n_restart     = 1'b1;
                n_countdown   = n_interval;
                n_armed       = 1'b1;
                new_arm       = 1'b1;
            end
        end

        // probe countdown; an armed word this tick starts counting next tick
        if (n_armed && !new_arm) begin
            if (n_countdown <= RW'(1)) begin
                n_countdown = '0;
                n_armed     = 1'b0;
                if (n_engaged && !n_probing && in_allowed) begin
                    n_probing = 1'b1;
                    n_start   = 1'b1;
                end
            end else begin
                n_countdown = n_countdown - 1'b1;
            end
        end
    end

    // advance tick state on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engaged       <= 1'b0;
            r_probing       <= 1'b0;
            r_conn_active   <= 1'b0;
            r_restore_valid <= 1'b0;
            r_armed         <= 1'b0;
            r_conn_ticks    <= '0;
            r_since_restore <= '0;
            r_interval      <= lfbc_pkg::RST_PROBE_MIN;
            r_countdown     <= '0;
        end else if (s_accept) begin
            r_engaged       <= n_engaged;
            r_probing       <= n_probing;
            r_conn_active   <= n_conn_active;
            r_restore_valid <= n_restore_valid;
            r_armed         <= n_armed;
            r_conn_ticks    <= n_conn_ticks;
            r_since_restore <= n_since_restore;
            r_interval      <= n_interval;
            r_countdown     <= n_countdown;
        end
    end

    // result register: load on accept, drop once drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out.fallback_engaged <= n_engaged;
            r_out.start_probe      <= n_start;
            r_out.restart_links    <= n_restart;
            r_out.current_interval <= n_interval;
        end
    end

    `LFBC_ASSERT_NOW(a_probe_needs_engaged, i_clk, i_rst_n, r_probing, r_engaged, "probe pending while not engaged")
    `LFBC_ASSERT_NOW(a_start_while_engaged, i_clk, i_rst_n, r_out_valid && r_out.start_probe, r_out.fallback_engaged, "probe requested while not engaged")
    `LFBC_ASSERT_NOW(a_no_start_and_restart, i_clk, i_rst_n, r_out_valid, !(r_out.start_probe && r_out.restart_links), "probe and restart in one tick")
    `LFBC_ASSERT_NEXT(a_denied_disengages, i_clk, i_rst_n, s_accept && !in_allowed, !r_out.fallback_engaged && !r_engaged && !r_armed, "fallback held after permission lost")

endmodule
